// ----- sv/tlpm_pkg.sv -----
// Shared types and constants for the trie longest-prefix-match unit.
// No dependencies; imported by the front, the engine and the top level.
package tlpm_pkg;

  localparam int ADDR_BITS       = 32;
  localparam int LEN_W           = 6;
  localparam int HOP_W           = 32;
  localparam int TLPM_NODE_COUNT = 4096;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;

  // classified request, address already in walk order, length saturated
  typedef struct packed {
    logic                 kind;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0]     len;
    logic [HOP_W-1:0]     hop;
  } cmd_t;

  typedef struct packed {
    logic [HOP_W-1:0] hop;
    logic             status;
  } res_t;

endpackage

// ----- sv/tlpm_front.sv -----
// Front end: takes requests, restores byte order, saturates the length
// and holds them in a two-entry queue for the engine. Uses tlpm_pkg.
module tlpm_front
  import tlpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_kind,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [LEN_W-1:0]     in_prefix_length,
  input  logic [HOP_W-1:0]     in_next_hop,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       enq;
  logic       do_push, do_pop;

  // classify the incoming request
  always_comb begin
    enq.kind = in_kind;
    enq.addr = {in_address[7:0], in_address[15:8], in_address[23:16], in_address[31:24]};
    enq.len  = (in_prefix_length > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : in_prefix_length;
    enq.hop  = in_next_hop;
  end

  assign in_full   = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_valid && cmd_ready;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold queued requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= enq;
    end
  end

endmodule

// ----- sv/tlpm_engine.sv -----
// Back end: walks the trie one level per cycle over the node memory,
// allocates new nodes for inserts and produces one result per request.
// Uses tlpm_pkg.
module tlpm_engine
  import tlpm_pkg::*;
#(
  parameter int NODE_COUNT = TLPM_NODE_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);

  typedef struct packed {
    logic [HOP_W-1:0] hop;
    logic [IDX_W-1:0] child1;
    logic [IDX_W-1:0] child0;
  } node_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_BUILD = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  node_t            mem [NODE_COUNT];
  node_t            rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  node_t            wr_data;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [LEN_W-1:0] depth_r, depth_nxt;
  logic             from_root_r, from_root_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [HOP_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  node_t            root_r, root_nxt;
  res_t             pend_r, pend_nxt;

  node_t            cur_node, upd_node, build_node;
  logic             bit_one, at_end, stop, no_room, last;
  logic [IDX_W-1:0] child, new_idx, chain_idx;
  logic [LEN_W-1:0] limit, missing;
  logic [CNT_W-1:0] free_cnt;
  logic [HOP_W-1:0] best_eff;

  // decode the current walk step
  always_comb begin
    cur_node  = from_root_r ? root_r : rdata_r;
    bit_one   = cmd_r.addr[~depth_r[4:0]];
    child     = bit_one ? cur_node.child1 : cur_node.child0;
    limit     = (cmd_r.kind == KIND_LOOKUP) ? LEN_W'(ADDR_BITS) : cmd_r.len;
    at_end    = (depth_r == limit);
    stop      = at_end || (child == '0);
    best_eff  = (!from_root_r && cur_node.hop != '0) ? cur_node.hop : best_r;
    missing   = limit - depth_r;
    free_cnt  = CNT_W'(NODE_COUNT) - used_r;
    no_room   = CNT_W'(missing) > free_cnt;
    new_idx   = used_r[IDX_W-1:0];
    chain_idx = IDX_W'(used_r + CNT_W'(1));
    last      = (depth_r == cmd_r.len);

    // update of the node where the walk stopped
    upd_node = cur_node;
    if (at_end) begin
      upd_node.hop = cmd_r.hop;
    end else if (bit_one) begin
      upd_node.child1 = new_idx;
    end else begin
      upd_node.child0 = new_idx;
    end

    // freshly allocated node, linked to the next one unless it is the last
    build_node = '0;
    if (last) begin
      build_node.hop = cmd_r.hop;
    end else if (bit_one) begin
      build_node.child1 = chain_idx;
    end else begin
      build_node.child0 = chain_idx;
    end
  end

  assign rd_addr   = child;
  assign cmd_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = pend_r;

  // sequence one request
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    depth_nxt     = depth_r;
    from_root_nxt = from_root_r;
    cur_idx_nxt   = cur_idx_r;
    best_nxt      = best_r;
    used_nxt      = used_r;
    root_nxt      = root_r;
    pend_nxt      = pend_r;
    wr_en         = 1'b0;
    wr_addr       = cur_idx_r;
    wr_data       = upd_node;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt       = cmd;
          depth_nxt     = '0;
          from_root_nxt = 1'b1;
          best_nxt      = root_r.hop;
          state_nxt     = ST_WALK;
        end
      end
      ST_WALK: begin
        best_nxt = best_eff;
        if (!stop) begin
          from_root_nxt = 1'b0;
          cur_idx_nxt   = child;
          depth_nxt     = depth_r + LEN_W'(1);
        end else if (cmd_r.kind == KIND_LOOKUP) begin
          pend_nxt.hop    = best_eff;
          pend_nxt.status = STATUS_OK;
          state_nxt       = ST_DONE;
        end else if (no_room) begin
          // drop the insert untouched
          pend_nxt.hop    = '0;
          pend_nxt.status = STATUS_POOL_FULL;
          state_nxt       = ST_DONE;
        end else begin
          if (from_root_r) begin
            root_nxt = upd_node;
          end else begin
            wr_en = 1'b1;
          end
          pend_nxt.hop    = '0;
          pend_nxt.status = STATUS_OK;
          if (at_end) begin
            state_nxt = ST_DONE;
          end else begin
            depth_nxt = depth_r + LEN_W'(1);
            state_nxt = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        wr_en     = 1'b1;
        wr_addr   = new_idx;
        wr_data   = build_node;
        used_nxt  = used_r + CNT_W'(1);
        depth_nxt = depth_r + LEN_W'(1);
        if (last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= CNT_W'(1);
      root_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      root_r  <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    depth_r     <= depth_nxt;
    from_root_r <= from_root_nxt;
    cur_idx_r   <= cur_idx_nxt;
    best_r      <= best_nxt;
    pend_r      <= pend_nxt;
  end

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

endmodule

// ----- sv/trie_longest_prefix_match_unit.sv -----
// Top level of the trie longest-prefix-match unit: front queue, trie
// engine and the result register. Uses tlpm_pkg, tlpm_front, tlpm_engine.
//
//   channel  direction  handshake     payload
//   in_      request    push / full   kind, address, prefix_length, next_hop
//   out_     result     pop / empty   found_hop, status
//
// One request at a time in the engine: a lookup visits one trie level per
// cycle, including the root (the node memory read port sets the pace),
// between the idle state taking it and the done state handing it off. An
// insert walks the path, then builds any missing nodes, one per cycle.
// The front holds two requests, so input continues while a result waits.
// Reset empties both queues and the trie; node memory needs no clearing.
module trie_longest_prefix_match_unit
  import tlpm_pkg::*;
#(
  parameter int NODE_COUNT = TLPM_NODE_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_kind,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [LEN_W-1:0]     in_prefix_length,
  input  logic [HOP_W-1:0]     in_next_hop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [HOP_W-1:0]     out_found_hop,
  output logic                 out_status
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic res_valid, res_ready;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  tlpm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_prefix_length (in_prefix_length),
    .in_next_hop      (in_next_hop),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd)
  );

  tlpm_engine #(
    .NODE_COUNT (NODE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // hold the result until it is popped
  assign res_ready = !out_valid_r || out_pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_found_hop = out_res_r.hop;
  assign out_status    = out_res_r.status;

`ifndef SYNTHESIS
  // a dropped insert never carries a hop
  a_full_no_hop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == STATUS_POOL_FULL) |-> (out_found_hop == '0))
    else $error("pool-full result with non-zero hop");

  // engine keeps offering a blocked result
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("engine result lost while output register full");

  // engine takes no request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !cmd_ready)
    else $error("engine idle while result pending");

  // reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
`endif

endmodule
